>>> src/igc_pkg.sv
// Package for the ideal-gas conserved-to-complete converter.
// Holds the word types, status codes and pipeline constants; depends on nothing.
package igc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int GAMMA_FRAC = 16;
  localparam int GAMMA_W    = 18;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;

  // Kinetic energy division: 64-bit dividend, one quotient bit per stage.
  localparam int DIV1_BITS  = 64;
  // Temperature division: 32-bit pressure magnitude scaled by the fraction bits.
  localparam int DIV2_BITS  = 32 + FRAC_BITS;
  localparam int SQRT_STEPS = 32;

  localparam int SQ_SHL = (FRAC_BITS >= GAMMA_FRAC) ? FRAC_BITS - GAMMA_FRAC : 0;
  localparam int SQ_SHR = (FRAC_BITS <  GAMMA_FRAC) ? GAMMA_FRAC - FRAC_BITS : 0;

  localparam int LATENCY = 1 + DIV1_BITS + 3 + DIV2_BITS + 1 + 1 + SQRT_STEPS + 1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_DENSITY = 2'd1,
    ST_NEG_TEMP    = 2'd2,
    ST_SAT         = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] cell_density;
    logic signed [31:0] cell_momentum;
    logic signed [31:0] cell_energy;
  } cons_t;

  typedef struct packed {
    logic signed [31:0] out_species;
    logic signed [31:0] out_pressure;
    logic signed [31:0] out_temperature;
    logic        [31:0] out_sound_speed;
    logic        [1:0]  out_status;
  } complete_t;

  // Values that ride alongside the square root pipeline.
  typedef struct packed {
    logic signed [31:0] rho;
    logic signed [31:0] p;
    logic signed [31:0] t;
    status_t            status;
  } sq_side_t;

endpackage

>>> src/igc_sqrt.sv
// Pipelined integer square root, two radicand bits per stage.
// Depends on igc_pkg for the stage count and the side data type.
module igc_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [63:0]      x,
  input  igc_pkg::sq_side_t side_in,
  output logic             out_valid,
  output logic [31:0]      root,
  output igc_pkg::sq_side_t side_out
);
  import igc_pkg::*;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] xs;
    sq_side_t    side;
  } sq_stage_t;

  sq_stage_t st [0:SQRT_STEPS];
  logic      vl [0:SQRT_STEPS];

  assign st[0] = '{rem: '0, root: '0, xs: x, side: side_in};
  assign vl[0] = in_valid;

  genvar k;
  for (k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [35:0] cur;
    logic [35:0] trial;
    logic        ge;

    assign cur   = {st[k].rem, st[k].xs[63:62]};
    assign trial = {2'b00, st[k].root, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else begin
        vl[k+1] <= vl[k];
      end
    end

    always_ff @(posedge clk) begin
      st[k+1].rem  <= ge ? 34'(cur - trial) : cur[33:0];
      st[k+1].root <= {st[k].root[30:0], ge};
      st[k+1].xs   <= {st[k].xs[61:0], 2'b00};
      st[k+1].side <= st[k].side;
    end
  end

  assign out_valid = vl[SQRT_STEPS];
  assign root      = st[SQRT_STEPS].root;
  assign side_out  = st[SQRT_STEPS].side;

endmodule

>>> src/ideal_gas_cons_to_complete.sv
// Top level of the ideal-gas conserved-to-complete converter.
// Depends on igc_pkg and instantiates igc_sqrt.
//
// One cell word is taken on every clock where start is high; busy is always low.
// Each result appears on complete with done high, one result per clock at full
// rate, in the order the cell words were taken. The pipeline runs through the
// 64-stage kinetic energy divider, the 48-stage temperature divider and the
// 32-stage square root, each producing one bit per stage. Results cannot be held
// off, so the receiver must take every word in its cycle. Write gamma_ratio
// through cfg_we/cfg_wdata only while no cell is in flight.
module ideal_gas_cons_to_complete (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  igc_pkg::cons_t                 cons,
  input  logic                           cfg_we,
  input  logic [igc_pkg::GAMMA_W-1:0]    cfg_wdata,
  output logic                           done,
  output igc_pkg::complete_t             complete
);
  import igc_pkg::*;

  logic [GAMMA_W-1:0] gamma;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (cfg_we) begin
      gamma <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // Square of the momentum magnitude.
  logic [31:0] mabs_in;
  logic [63:0] msq_in;

  assign mabs_in = cons.cell_momentum[31] ? 32'(-cons.cell_momentum) : cons.cell_momentum;
  assign msq_in  = mabs_in * mabs_in;

  // Kinetic energy divider: msq / (2 * rho).
  typedef struct packed {
    logic signed [31:0] rho;
    logic signed [31:0] en;
    logic [32:0]        rem;
    logic [63:0]        acc;
  } d1_t;

  d1_t  d1 [0:DIV1_BITS];
  logic d1_v [0:DIV1_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v[0] <= 1'b0;
    end else begin
      d1_v[0] <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    d1[0] <= '{rho: cons.cell_density, en: cons.cell_energy, rem: '0, acc: msq_in};
  end

  genvar k;
  for (k = 0; k < DIV1_BITS; k++) begin : g_div1
    logic [33:0] cur;
    logic [33:0] dvs;
    logic        ge;

    assign cur = {d1[k].rem, d1[k].acc[63]};
    assign dvs = {1'b0, d1[k].rho, 1'b0};
    assign ge  = cur >= dvs;

    always_ff @(posedge clk) begin
      if (rst) begin
        d1_v[k+1] <= 1'b0;
      end else begin
        d1_v[k+1] <= d1_v[k];
      end
    end

    always_ff @(posedge clk) begin
      d1[k+1].rho <= d1[k].rho;
      d1[k+1].en  <= d1[k].en;
      d1[k+1].rem <= ge ? 33'(cur - dvs) : cur[32:0];
      d1[k+1].acc <= {d1[k].acc[62:0], ge};
    end
  end

  // Internal energy and the operands of the pressure product.
  logic signed [64:0] eps;
  logic signed [18:0] gm1;
  logic [64:0]        eps_mag;
  logic [48:0]        a_next;
  logic [17:0]        b_next;

  assign eps     = $signed({{33{d1[DIV1_BITS].en[31]}}, d1[DIV1_BITS].en})
                 - $signed({1'b0, d1[DIV1_BITS].acc});
  assign gm1     = $signed({1'b0, gamma}) - 19'sd65536;
  assign eps_mag = eps[64] ? 65'(-eps) : 65'(eps);
  assign a_next  = (eps_mag > 65'(49'h1_0000_0000_0000)) ? 49'h1_0000_0000_0000
                                                         : eps_mag[48:0];
  assign b_next  = gm1[18] ? 18'(-gm1) : gm1[17:0];

  logic               b1_v;
  logic signed [31:0] b1_rho;
  logic [48:0]        b1_a;
  logic [17:0]        b1_b;
  logic               b1_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else begin
      b1_v <= d1_v[DIV1_BITS];
    end
  end

  always_ff @(posedge clk) begin
    b1_rho <= d1[DIV1_BITS].rho;
    b1_a   <= a_next;
    b1_b   <= b_next;
    b1_neg <= eps[64] ^ gm1[18];
  end

  // Pressure magnitude as two partial products.
  logic [33:0] lo_prod;
  assign lo_prod = b1_a[15:0] * b1_b;

  logic               b2_v;
  logic signed [31:0] b2_rho;
  logic [50:0]        b2_hi;
  logic [17:0]        b2_lo;
  logic               b2_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_v <= 1'b0;
    end else begin
      b2_v <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    b2_rho <= b1_rho;
    b2_hi  <= b1_a[48:16] * b1_b;
    b2_lo  <= lo_prod[33:16];
    b2_neg <= b1_neg;
  end

  // Saturated pressure; this register is the first stage of the second divider.
  logic [51:0]        mag;
  logic signed [31:0] p_next;
  logic               p_sat;

  assign mag = 52'(b2_hi) + 52'(b2_lo);

  always_comb begin
    p_sat  = 1'b0;
    p_next = 32'(mag);
    if (b2_neg) begin
      if (mag > 52'h8000_0000) begin
        p_sat  = 1'b1;
        p_next = 32'sh8000_0000;
      end else begin
        p_next = 32'(-mag);
      end
    end else if (mag > 52'h7FFF_FFFF) begin
      p_sat  = 1'b1;
      p_next = 32'sh7FFF_FFFF;
    end
  end

  typedef struct packed {
    logic signed [31:0]    rho;
    logic signed [31:0]    p;
    logic                  sat;
    logic [31:0]           rem;
    logic [DIV2_BITS-1:0]  acc;
  } d2_t;

  d2_t  d2 [0:DIV2_BITS];
  logic d2_v [0:DIV2_BITS];
  logic [31:0] pmag_next;

  assign pmag_next = p_next[31] ? 32'(-p_next) : p_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_v[0] <= 1'b0;
    end else begin
      d2_v[0] <= b2_v;
    end
  end

  always_ff @(posedge clk) begin
    d2[0] <= '{rho: b2_rho, p: p_next, sat: p_sat, rem: '0,
               acc: {pmag_next, {FRAC_BITS{1'b0}}}};
  end

  // Temperature divider: (|p| << FRAC_BITS) / rho.
  for (k = 0; k < DIV2_BITS; k++) begin : g_div2
    logic [32:0] cur;
    logic [32:0] dvs;
    logic        ge;

    assign cur = {d2[k].rem, d2[k].acc[DIV2_BITS-1]};
    assign dvs = {1'b0, d2[k].rho};
    assign ge  = cur >= dvs;

    always_ff @(posedge clk) begin
      if (rst) begin
        d2_v[k+1] <= 1'b0;
      end else begin
        d2_v[k+1] <= d2_v[k];
      end
    end

    always_ff @(posedge clk) begin
      d2[k+1].rho <= d2[k].rho;
      d2[k+1].p   <= d2[k].p;
      d2[k+1].sat <= d2[k].sat;
      d2[k+1].rem <= ge ? 32'(cur - dvs) : cur[31:0];
      d2[k+1].acc <= {d2[k].acc[DIV2_BITS-2:0], ge};
    end
  end

  // Signed, saturated temperature and the status code.
  d2_t                d2e;
  logic signed [31:0] t_next;
  logic               t_sat;
  status_t            st_next;

  assign d2e = d2[DIV2_BITS];

  always_comb begin
    t_sat  = 1'b0;
    t_next = 32'(d2e.acc);
    if (d2e.p[31]) begin
      if (d2e.acc > DIV2_BITS'(33'h8000_0000)) begin
        t_sat  = 1'b1;
        t_next = 32'sh8000_0000;
      end else begin
        t_next = 32'(-d2e.acc);
      end
    end else if (d2e.acc > DIV2_BITS'(32'h7FFF_FFFF)) begin
      t_sat  = 1'b1;
      t_next = 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    if (d2e.rho <= 0) begin
      st_next = ST_BAD_DENSITY;
    end else if (d2e.p[31]) begin
      st_next = ST_NEG_TEMP;
    end else if (d2e.sat || t_sat) begin
      st_next = ST_SAT;
    end else begin
      st_next = ST_OK;
    end
  end

  logic     e_v;
  sq_side_t e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else begin
      e_v <= d2_v[DIV2_BITS];
    end
  end

  always_ff @(posedge clk) begin
    e_side.rho    <= d2e.rho;
    e_side.p      <= (st_next == ST_BAD_DENSITY) ? '0 : d2e.p;
    e_side.t      <= (st_next == ST_BAD_DENSITY) ? '0 : t_next;
    e_side.status <= st_next;
  end

  // Radicand gamma * T, rescaled to twice the fraction bits.
  logic [49:0] gx;
  logic        x_v;
  logic [63:0] x_reg;
  sq_side_t    x_side;

  assign gx = gamma * e_side.t;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_v <= 1'b0;
    end else begin
      x_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    x_reg  <= (64'(gx) << SQ_SHL) >> SQ_SHR;
    x_side <= e_side;
  end

  logic        sq_v;
  logic [31:0] sq_root;
  sq_side_t    sq_side;

  igc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (x_v),
    .x        (x_reg),
    .side_in  (x_side),
    .out_valid(sq_v),
    .root     (sq_root),
    .side_out (sq_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    complete.out_species     <= sq_side.rho;
    complete.out_pressure    <= sq_side.p;
    complete.out_temperature <= sq_side.t;
    complete.out_sound_speed <= (sq_side.status == ST_OK || sq_side.status == ST_SAT)
                                ? sq_root : '0;
    complete.out_status      <= sq_side.status;
  end

  // Every result word traces back to exactly one accepted cell word.
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result word without a matching cell word");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("cell word produced no result word");

  a_bad_density_zero: assert property (@(posedge clk) disable iff (rst)
    (done && complete.out_status == ST_BAD_DENSITY) |->
      (complete.out_pressure == 0 && complete.out_temperature == 0 &&
       complete.out_sound_speed == 0))
    else $error("nonpositive density must clear the derived fields");

  a_neg_temp: assert property (@(posedge clk) disable iff (rst)
    (done && complete.out_status == ST_NEG_TEMP) |->
      (complete.out_sound_speed == 0 && complete.out_pressure < 0))
    else $error("negative temperature status inconsistent with outputs");

endmodule

>>> tb/testbench.sv
// Testbench for the ideal-gas conserved-to-complete converter.
// Drives random and corner cell words, predicts each complete word and checks it.
// Depends on igc_pkg and the ideal_gas_cons_to_complete top level.
module testbench;
  import igc_pkg::*;

  localparam int DRAIN_CYCLES = LATENCY + 20;
  localparam int STALL_LIMIT  = 4 * LATENCY + 2000;

  class cell_scoreboard;
    complete_t pending[$];
    logic [GAMMA_W-1:0] gamma;
    int errors;

    function new();
      gamma = GAMMA_RESET;
      errors = 0;
    endfunction

    static function logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= r + bitv) begin
          x = x - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
      return r;
    endfunction

    // Work out the complete word of one cell with the current gamma.
    function complete_t convert(cons_t c);
      complete_t res;
      longint rho, mom, en, eps, gm1, p, t;
      logic [63:0] mabs, ke, a, b, mag, pmag, tmag, x;
      bit sat, neg;
      rho = c.cell_density;
      mom = c.cell_momentum;
      en = c.cell_energy;
      sat = 0;
      res = '0;
      res.out_species = c.cell_density;
      if (rho <= 0) begin
        res.out_status = ST_BAD_DENSITY;
        return res;
      end
      mabs = mom < 0 ? -mom : mom;
      ke = (mabs * mabs) / (rho * 2);
      eps = en - longint'(ke);
      gm1 = longint'({46'd0, gamma}) - (64'sd1 <<< GAMMA_FRAC);
      neg = (eps < 0) != (gm1 < 0);
      a = eps < 0 ? -eps : eps;
      b = gm1 < 0 ? -gm1 : gm1;
      if (a > (64'd1 << 48)) a = 64'd1 << 48;
      mag = (a >> GAMMA_FRAC) * b + (((a & 64'hFFFF) * b) >> GAMMA_FRAC);
      p = neg ? -longint'(mag) : longint'(mag);
      if (p > 64'sh7FFFFFFF) begin p = 64'sh7FFFFFFF; sat = 1; end
      if (p < -64'sh80000000) begin p = -64'sh80000000; sat = 1; end
      pmag = p < 0 ? -p : p;
      tmag = (pmag << FRAC_BITS) / rho;
      t = p < 0 ? -longint'(tmag) : longint'(tmag);
      if (t > 64'sh7FFFFFFF) begin t = 64'sh7FFFFFFF; sat = 1; end
      if (t < -64'sh80000000) begin t = -64'sh80000000; sat = 1; end
      res.out_pressure = p[31:0];
      res.out_temperature = t[31:0];
      if (p < 0) begin
        res.out_status = ST_NEG_TEMP;
      end else begin
        x = {46'd0, gamma} * t;
        x = (x << SQ_SHL) >> SQ_SHR;
        res.out_sound_speed = isqrt(x);
        res.out_status = sat ? ST_SAT : ST_OK;
      end
      return res;
    endfunction

    function void note_cell(cons_t c);
      pending.push_back(convert(c));
    endfunction

    function void check_word(complete_t got);
      complete_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.out_species !== want.out_species) begin
        $display("%0t: species expected %h actual %h", $time,
                 want.out_species, got.out_species);
        errors++;
      end
      if (got.out_pressure !== want.out_pressure) begin
        $display("%0t: pressure expected %h actual %h", $time,
                 want.out_pressure, got.out_pressure);
        errors++;
      end
      if (got.out_temperature !== want.out_temperature) begin
        $display("%0t: temperature expected %h actual %h", $time,
                 want.out_temperature, got.out_temperature);
        errors++;
      end
      if (got.out_sound_speed !== want.out_sound_speed) begin
        $display("%0t: sound speed expected %h actual %h", $time,
                 want.out_sound_speed, got.out_sound_speed);
        errors++;
      end
      if (got.out_status !== want.out_status) begin
        $display("%0t: status expected %0d actual %0d", $time,
                 want.out_status, got.out_status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  cons_t cons = '0;
  logic cfg_we = 0;
  logic [GAMMA_W-1:0] cfg_wdata = '0;
  logic done;
  complete_t complete;

  cell_scoreboard board = new();
  int idle_cycles = 0;

  ideal_gas_cons_to_complete dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cons(cons),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .complete(complete)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_word(complete);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_cell(cons_t c, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    start <= 1;
    cons <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_cell(c);
  endtask

  task automatic go_idle();
    @(negedge clk);
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gamma(logic [GAMMA_W-1:0] g);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we <= 0;
    board.gamma = g;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 32'h00FF_FFFF);
      2: return -$urandom_range(0, 32'h00FF_FFFF);
      3: return $urandom_range(32'h0000_8000, 32'h0010_0000);
      4: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  // Mostly physical cells: positive density, moderate momentum, nonnegative energy.
  function automatic cons_t rand_cell();
    cons_t c;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      c.cell_density = $urandom_range(32'h0000_0400, 32'h0100_0000);
      c.cell_momentum = $signed(32'($urandom())) >>> $urandom_range(4, 20);
      c.cell_energy = $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 16);
    end else begin
      c.cell_density = rand_word();
      c.cell_momentum = rand_word();
      c.cell_energy = rand_word();
    end
    return c;
  endfunction

  task automatic corner_cells();
    cons_t c;
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
              32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000};
    foreach (edges[i]) begin
      c.cell_density = edges[i];
      c.cell_momentum = edges[(i + 1) % 6];
      c.cell_energy = edges[(i + 3) % 6];
      send_cell(c, 0);
    end
    // Ordinary cell at rest, then one with a kinetic part bigger than energy.
    send_cell('{32'h0001_0000, 32'h0000_0000, 32'h0002_0000}, 0);
    send_cell('{32'h0001_0000, 32'h0004_0000, 32'h0001_0000}, 1);
    // Temperature large enough to clip; pressure clips only at a large gamma.
    send_cell('{32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF}, 0);
    send_cell('{32'h0000_0100, 32'h0000_0010, 32'h4000_0000}, 0);
    // Huge momentum over tiny density pushes eps far negative.
    send_cell('{32'h0000_0001, 32'h8000_0000, 32'h8000_0000}, 0);
    send_cell('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1);
    send_cell('{32'h0000_0001, 32'h0000_0001, 32'h0000_0000}, 0);
    send_cell('{32'h8000_0000, 32'h0001_0000, 32'h0001_0000}, 0);
  endtask

  initial begin
    logic [GAMMA_W-1:0] gammas[6];
    gammas = '{18'd91750, 18'd65537, 18'd196608, 18'd65536, 18'd0, 18'h3FFFF};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    corner_cells();
    foreach (gammas[k]) begin
      go_idle();
      write_gamma(k == 5 ? 18'($urandom_range(65537, 196608)) : gammas[k]);
      if (k >= 3) corner_cells();
      repeat (k == 0 ? 800 : 200) send_cell(rand_cell(), $urandom_range(0, 3) != 0);
    end
    go_idle();
    write_gamma(18'($urandom()));
    repeat (50) send_cell(rand_cell(), 1);
    go_idle();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
